// ===== src/msrc_pkg.sv =====
// ----------------------------------------------------------------------------
// msrc_pkg: shared types and constants of the motor speed ramp controller
// Command codes, pin patterns, ramp mode codes, register indexes, word types
// and the wheel duty clamp.
// ----------------------------------------------------------------------------
`default_nettype none

package msrc_pkg;

	localparam int unsigned CFG_ADDR_W = 3;
	localparam int unsigned CFG_DATA_W = 16;

	// register indexes
	localparam logic [CFG_ADDR_W-1:0] CFG_LEFT_OFFSET   = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] CFG_RIGHT_OFFSET  = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_STEP     = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_LIMIT    = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] CFG_RAMP_INTERVAL = 3'd4;

	localparam logic [6:0]  MAX_PCT      = 7'd100;
	localparam logic [6:0]  TURN_SPEED   = 7'd25;
	localparam logic [6:0]  BACK_SPEED   = 7'd20;
	localparam logic [6:0]  RST_SPEED    = 7'd20;
	localparam logic [6:0]  RST_STEP     = 7'd2;
	localparam logic [6:0]  RST_LIMIT    = 7'd100;
	localparam logic [15:0] RST_INTERVAL = 16'd2000;

	localparam logic [3:0] PINS_OFF  = 4'h0;
	localparam logic [3:0] PINS_FWD  = 4'h5;
	localparam logic [3:0] PINS_BACK = 4'hA;

	// ramp mode codes as reported
	localparam logic [1:0] MODE_IDLE  = 2'd0;
	localparam logic [1:0] MODE_ACCEL = 2'd1;
	localparam logic [1:0] MODE_DECEL = 2'd2;

	typedef enum logic [3:0] {
		FN_TICK      = 4'd0,
		FN_STOP      = 4'd1,
		FN_FWD       = 4'd2,
		FN_BACK      = 4'd3,
		FN_LEFT      = 4'd4,
		FN_RIGHT     = 4'd5,
		FN_APPLY     = 4'd6,
		FN_ACCEL_ON  = 4'd7,
		FN_ACCEL_OFF = 4'd8,
		FN_DECEL_ON  = 4'd9,
		FN_DECEL_OFF = 4'd10,
		FN_LOAD      = 4'd11
	} func_t;

	typedef enum logic [2:0] {
		RS_IDLE  = 3'b001,
		RS_ACCEL = 3'b010,
		RS_DECEL = 3'b100
	} ramp_state_t;

	typedef struct packed {
		logic [3:0] func;
		logic [6:0] new_speed_value;
	} in_word_t;

	typedef struct packed {
		logic [3:0] dir_pins;
		logic [6:0] left_duty;
		logic [6:0] right_duty;
		logic       report_valid;
		logic [6:0] report_speed;
		logic [1:0] ramp_mode_out;
	} out_word_t;

	typedef struct packed {
		logic signed [7:0] left_offset;
		logic signed [7:0] right_offset;
		logic [6:0]        ramp_step;
		logic [6:0]        ramp_limit;
		logic [15:0]       ramp_interval;
	} cfg_regs_t;

	// speed plus signed trim, clamped to 0..100
	function automatic logic [6:0] duty_of(input logic [6:0] spd, input logic signed [7:0] off);
		logic [9:0] sum;
		sum = {3'b000, spd} + {{2{off[7]}}, off};
		if (sum[9]) begin
			return 7'd0;
		end else if (sum[8:0] > {2'b00, MAX_PCT}) begin
			return MAX_PCT;
		end else begin
			return sum[6:0];
		end
	endfunction

endpackage

`default_nettype wire

// ===== src/msrc_cfg.sv =====
// ----------------------------------------------------------------------------
// msrc_cfg: configuration registers
// Holds wheel trims and ramp settings, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module msrc_cfg import msrc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	output cfg_regs_t                  regs
);

	cfg_regs_t regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.left_offset   <= 8'sd0;
			regs_q.right_offset  <= 8'sd0;
			regs_q.ramp_step     <= RST_STEP;
			regs_q.ramp_limit    <= RST_LIMIT;
			regs_q.ramp_interval <= RST_INTERVAL;
		end else if (cfg_we) begin
			case (cfg_addr)
				CFG_LEFT_OFFSET:   regs_q.left_offset   <= signed'(cfg_wdata[7:0]);
				CFG_RIGHT_OFFSET:  regs_q.right_offset  <= signed'(cfg_wdata[7:0]);
				CFG_RAMP_STEP:     regs_q.ramp_step     <= cfg_wdata[6:0];
				CFG_RAMP_LIMIT:    regs_q.ramp_limit    <= cfg_wdata[6:0];
				CFG_RAMP_INTERVAL: regs_q.ramp_interval <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign regs = regs_q;

endmodule

`default_nettype wire

// ===== src/msrc_core.sv =====
// ----------------------------------------------------------------------------
// msrc_core: motor command state and next-state logic
// Keeps speed, ramp state, tick counter, pins and duties; decodes one word
// per cycle, with the state updated only while fire is high, and forms its result.
// ----------------------------------------------------------------------------
`default_nettype none

module msrc_core import msrc_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      fire,
	input  wire in_word_t  item,
	input  wire cfg_regs_t cfg,
	output out_word_t      result
);

	logic [6:0]  cur_speed_q, cur_speed_d;
	ramp_state_t mode_q, mode_d;
	logic [15:0] tick_q, tick_d;
	logic [3:0]  pins_q, pins_d;
	logic [6:0]  left_q, left_d;
	logic [6:0]  right_q, right_d;

	logic        rep_valid;
	logic [6:0]  rep_speed;
	logic        do_step;
	logic        step_accel;
	logic [15:0] tick_inc;
	logic [15:0] ivl;
	logic [6:0]  lim;
	logic [7:0]  acc_sum;
	logic [6:0]  dec_val;
	logic [6:0]  load_val;
	logic [1:0]  mode_code;

	assign ivl      = (cfg.ramp_interval == 16'd0) ? 16'd1 : cfg.ramp_interval;
	assign lim      = (cfg.ramp_limit > MAX_PCT) ? MAX_PCT : cfg.ramp_limit;
	assign acc_sum  = {1'b0, cur_speed_q} + {1'b0, cfg.ramp_step};
	assign dec_val  = cur_speed_q - cfg.ramp_step;
	assign tick_inc = tick_q + 16'd1;
	assign load_val = (item.new_speed_value > MAX_PCT) ? MAX_PCT : item.new_speed_value;

	always_comb begin
		cur_speed_d = cur_speed_q;
		mode_d      = mode_q;
		tick_d      = tick_q;
		pins_d      = pins_q;
		left_d      = left_q;
		right_d     = right_q;
		rep_valid   = 1'b0;
		rep_speed   = 7'd0;
		do_step     = 1'b0;
		step_accel  = 1'b0;

		case (func_t'(item.func))
			FN_TICK: begin
				if (mode_q != RS_IDLE) begin
					tick_d     = tick_inc;
					do_step    = (tick_inc >= ivl);
					step_accel = (mode_q == RS_ACCEL);
				end
			end
			FN_STOP: begin
				pins_d  = PINS_OFF;
				left_d  = 7'd0;
				right_d = 7'd0;
			end
			FN_FWD: begin
				pins_d  = PINS_FWD;
				left_d  = duty_of(cur_speed_q, cfg.left_offset);
				right_d = duty_of(cur_speed_q, cfg.right_offset);
			end
			FN_BACK: begin
				pins_d  = PINS_BACK;
				left_d  = duty_of(BACK_SPEED, cfg.left_offset);
				right_d = duty_of(BACK_SPEED, cfg.right_offset);
			end
			FN_LEFT: begin
				pins_d  = PINS_FWD;
				left_d  = 7'd0;
				right_d = duty_of(TURN_SPEED, cfg.right_offset);
			end
			FN_RIGHT: begin
				pins_d  = PINS_FWD;
				left_d  = duty_of(TURN_SPEED, cfg.left_offset);
				right_d = 7'd0;
			end
			FN_APPLY: begin
				left_d  = duty_of(cur_speed_q, cfg.left_offset);
				right_d = duty_of(cur_speed_q, cfg.right_offset);
			end
			FN_ACCEL_ON: begin
				if (mode_q != RS_ACCEL) begin
					mode_d     = RS_ACCEL;
					pins_d     = PINS_FWD;
					left_d     = duty_of(cur_speed_q, cfg.left_offset);
					right_d    = duty_of(cur_speed_q, cfg.right_offset);
					do_step    = 1'b1;
					step_accel = 1'b1;
				end
			end
			FN_ACCEL_OFF: begin
				if (mode_q == RS_ACCEL) begin
					mode_d = RS_IDLE;
					tick_d = 16'd0;
				end
			end
			FN_DECEL_ON: begin
				if (mode_q != RS_DECEL) begin
					mode_d  = RS_DECEL;
					pins_d  = PINS_FWD;
					left_d  = duty_of(cur_speed_q, cfg.left_offset);
					right_d = duty_of(cur_speed_q, cfg.right_offset);
					do_step = 1'b1;
				end
			end
			FN_DECEL_OFF: begin
				if (mode_q == RS_DECEL) begin
					mode_d = RS_IDLE;
					tick_d = 16'd0;
				end
			end
			FN_LOAD: begin
				cur_speed_d = load_val;
			end
			default: ;
		endcase

		// one ramp step; reaching the end keeps the duties as they stand
		if (do_step) begin
			tick_d    = 16'd0;
			rep_valid = 1'b1;
			if (step_accel) begin
				if (acc_sum >= {1'b0, lim}) begin
					cur_speed_d = lim;
					rep_speed   = lim;
					mode_d      = RS_IDLE;
				end else begin
					cur_speed_d = acc_sum[6:0];
					rep_speed   = acc_sum[6:0];
					left_d      = duty_of(acc_sum[6:0], cfg.left_offset);
					right_d     = duty_of(acc_sum[6:0], cfg.right_offset);
				end
			end else begin
				if (cfg.ramp_step >= cur_speed_q) begin
					cur_speed_d = 7'd0;
					rep_speed   = 7'd0;
					mode_d      = RS_IDLE;
				end else begin
					cur_speed_d = dec_val;
					rep_speed   = dec_val;
					left_d      = duty_of(dec_val, cfg.left_offset);
					right_d     = duty_of(dec_val, cfg.right_offset);
				end
			end
		end
	end

	always_comb begin
		case (mode_d)
			RS_ACCEL: mode_code = MODE_ACCEL;
			RS_DECEL: mode_code = MODE_DECEL;
			default:  mode_code = MODE_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_speed_q <= RST_SPEED;
			mode_q      <= RS_IDLE;
			tick_q      <= 16'd0;
			pins_q      <= PINS_OFF;
			left_q      <= 7'd0;
			right_q     <= 7'd0;
		end else if (fire) begin
			cur_speed_q <= cur_speed_d;
			mode_q      <= mode_d;
			tick_q      <= tick_d;
			pins_q      <= pins_d;
			left_q      <= left_d;
			right_q     <= right_d;
		end
	end

	always_comb begin
		result.dir_pins      = pins_d;
		result.left_duty     = left_d;
		result.right_duty    = right_d;
		result.report_valid  = rep_valid;
		result.report_speed  = rep_speed;
		result.ramp_mode_out = mode_code;
	end

endmodule

`default_nettype wire

// ===== src/motor_speed_ramp_controller.sv =====
// ----------------------------------------------------------------------------
// motor_speed_ramp_controller: two-wheel H-bridge command block with speed ramp
// Decodes drive commands and millisecond ticks into direction pins, wheel
// duties and ramp speed reports.
// ----------------------------------------------------------------------------
// usage
//   in channel (in_valid/in_ready/in_data): one command or tick per word
//   out channel (out_valid/out_ready/out_data): exactly one result word per
//   input word, in order: pins, both duties, ramp report and ramp mode
//   cfg port (cfg_we/cfg_addr/cfg_wdata): trims and ramp settings, written
//   while no word is in flight
// timing
//   a word is held in the input register until it advances, is decoded
//   against the motor state there and is registered with out_valid in the
//   result register; throughput is one word per cycle unless out_ready
//   stalls; the state update is a single pass of add, compare and clamp
//   logic between the input and result registers
// reset and stall
//   reset empties both registers, sets speed 20, ramp idle, pins and duties
//   low, and loads the register defaults
//   when out_ready is low the result holds; one more word can be held in
//   the input register before in_ready falls
// ----------------------------------------------------------------------------
`default_nettype none

module motor_speed_ramp_controller import msrc_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire in_word_t              in_data,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output out_word_t                  out_data,
	input  wire logic                  cfg_we,
	input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

	cfg_regs_t cfg;
	in_word_t  in_data_s1;
	logic      in_valid_s1;
	out_word_t out_data_s2;
	logic      out_valid_s2;
	out_word_t result;
	logic      advance;

	assign advance  = in_valid_s1 && (!out_valid_s2 || out_ready);
	assign in_ready = !in_valid_s1 || advance;

	msrc_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.regs      (cfg)
	);

	msrc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (advance),
		.item   (in_data_s1),
		.cfg    (cfg),
		.result (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_ready) begin
			in_valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			in_data_s1 <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_ready) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_data_s2 <= result;
		end
	end

	assign out_valid = out_valid_s2;
	assign out_data  = out_data_s2;

`ifndef ASSERT_OFF
	// a decoded word always shows up on the output next cycle
	a_advance_fills: assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_s2)
		else $error("decoded word did not reach the result register");

	// backpressure only with both registers full and the output stalled
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> (in_valid_s1 && out_valid_s2 && !out_ready))
		else $error("in_ready low without a full stalled pipeline");

	// duties stay within percent range
	a_duty_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.left_duty <= MAX_PCT && out_data.right_duty <= MAX_PCT))
		else $error("wheel duty above 100");

	// only the three bridge patterns are ever driven
	a_pins_legal: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (out_data.dir_pins == PINS_OFF || out_data.dir_pins == PINS_FWD ||
			out_data.dir_pins == PINS_BACK))
		else $error("illegal H-bridge pin pattern");
`endif

endmodule

`default_nettype wire
